// ----- src/mi3_pkg.sv -----
package mi3_pkg;

    // Default element format: signed Q16.16.
    localparam int ELEMENT_WIDTH = 32;
    localparam int FRACTION_BITS = 16;

    // Nine matrix elements per item, nine adjugate entries per result.
    localparam int NUM_ELEMS = 9;

    // Multiply schedule of the front engine: two products per adjugate entry,
    // then a low and a high partial product for each of the three terms of the
    // first-row cofactor expansion of the determinant.
    localparam int ADJ_STEPS = 18;
    localparam int MUL_STEPS = 24;
    localparam int STEP_W    = 5;

    // Entries in the queue between the front engine and the dividers.
    localparam int QUEUE_DEPTH = 2;

endpackage

// ----- src/mi3_fifo.sv -----
module mi3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp;
    logic [PW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- src/mi3_front.sv -----
module mi3_front #(
    parameter int EW = mi3_pkg::ELEMENT_WIDTH
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic [mi3_pkg::NUM_ELEMS*EW-1:0]         i_data,
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic [mi3_pkg::NUM_ELEMS*(2*EW+1)+3*EW+3:0] o_job
);

    localparam int NE = mi3_pkg::NUM_ELEMS;
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 3;
    localparam int XW = EW + 1;
    localparam int SW = mi3_pkg::STEP_W;

    logic                 r_hold_vld;
    logic [NE*EW-1:0]     r_hold;
    logic signed [EW-1:0] r_mat [NE];
    logic signed [AW-1:0] r_adj [NE];
    logic signed [DW-1:0] r_det;
    logic                 r_busy;
    logic                 r_done;
    logic                 r_pv;
    logic [SW-1:0]        r_step;
    logic [SW-1:0]        r_pstep;
    logic signed [2*XW-1:0] r_prod;
    logic signed [XW-1:0] w_x;
    logic signed [XW-1:0] w_y;
    logic                 w_start;
    logic                 w_issue;

    assign o_ready = !r_hold_vld;
    assign w_start = r_hold_vld && !r_busy && !r_done;
    assign w_issue = r_busy && (r_step < SW'(mi3_pkg::MUL_STEPS));
    assign o_valid = r_done;

    // Operand selection for each step of the multiply schedule.
    always_comb begin
        w_x = '0;
        w_y = '0;
        case (r_step)
            5'd0:  begin w_x = XW'(r_mat[4]); w_y = XW'(r_mat[8]); end
            5'd1:  begin w_x = XW'(r_mat[5]); w_y = XW'(r_mat[7]); end
            5'd2:  begin w_x = XW'(r_mat[2]); w_y = XW'(r_mat[7]); end
            5'd3:  begin w_x = XW'(r_mat[1]); w_y = XW'(r_mat[8]); end
            5'd4:  begin w_x = XW'(r_mat[1]); w_y = XW'(r_mat[5]); end
            5'd5:  begin w_x = XW'(r_mat[2]); w_y = XW'(r_mat[4]); end
            5'd6:  begin w_x = XW'(r_mat[5]); w_y = XW'(r_mat[6]); end
            5'd7:  begin w_x = XW'(r_mat[3]); w_y = XW'(r_mat[8]); end
            5'd8:  begin w_x = XW'(r_mat[0]); w_y = XW'(r_mat[8]); end
            5'd9:  begin w_x = XW'(r_mat[2]); w_y = XW'(r_mat[6]); end
            5'd10: begin w_x = XW'(r_mat[2]); w_y = XW'(r_mat[3]); end
            5'd11: begin w_x = XW'(r_mat[0]); w_y = XW'(r_mat[5]); end
            5'd12: begin w_x = XW'(r_mat[3]); w_y = XW'(r_mat[7]); end
            5'd13: begin w_x = XW'(r_mat[4]); w_y = XW'(r_mat[6]); end
            5'd14: begin w_x = XW'(r_mat[1]); w_y = XW'(r_mat[6]); end
            5'd15: begin w_x = XW'(r_mat[0]); w_y = XW'(r_mat[7]); end
            5'd16: begin w_x = XW'(r_mat[0]); w_y = XW'(r_mat[4]); end
            5'd17: begin w_x = XW'(r_mat[1]); w_y = XW'(r_mat[3]); end
            5'd18: begin w_x = XW'(r_mat[0]); w_y = signed'({1'b0, r_adj[0][EW-1:0]}); end
            5'd19: begin w_x = XW'(r_mat[0]); w_y = r_adj[0][AW-1:EW]; end
            5'd20: begin w_x = XW'(r_mat[1]); w_y = signed'({1'b0, r_adj[3][EW-1:0]}); end
            5'd21: begin w_x = XW'(r_mat[1]); w_y = r_adj[3][AW-1:EW]; end
            5'd22: begin w_x = XW'(r_mat[2]); w_y = signed'({1'b0, r_adj[6][EW-1:0]}); end
            5'd23: begin w_x = XW'(r_mat[2]); w_y = r_adj[6][AW-1:EW]; end
            default: begin w_x = '0; w_y = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_hold <= i_data;
        end
        if (w_start) begin
            for (int i = 0; i < NE; i++) begin
                r_mat[i] <= r_hold[i*EW +: EW];
            end
            r_det <= '0;
        end
        r_prod  <= w_x * w_y;
        r_pstep <= r_step;
        if (r_pv) begin
            if (r_pstep < SW'(mi3_pkg::ADJ_STEPS)) begin
                for (int i = 0; i < NE; i++) begin
                    if (r_pstep[SW-1:1] == (SW-1)'(i)) begin
                        r_adj[i] <= r_pstep[0] ? r_adj[i] - r_prod[AW-1:0]
                                               : r_prod[AW-1:0];
                    end
                end
            end else if (!r_pstep[0]) begin
                r_det <= r_det + DW'(r_prod);
            end else begin
                r_det <= r_det + (DW'(r_prod) <<< EW);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_vld <= 1'b0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
            r_pv       <= 1'b0;
            r_step     <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_hold_vld <= 1'b1;
            end else if (w_start) begin
                r_hold_vld <= 1'b0;
            end
            if (w_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (w_issue) begin
                r_step <= r_step + 1'b1;
            end
            r_pv <= w_issue;
            if (r_pv && r_pstep == SW'(mi3_pkg::MUL_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (r_done && i_ready) begin
                r_done <= 1'b0;
            end
        end
    end

    // Job word: adjugate entries from the lowest bits, then determinant, then
    // the singular flag on top.
    always_comb begin
        for (int i = 0; i < NE; i++) begin
            o_job[i*AW +: AW] = r_adj[i];
        end
        o_job[NE*AW +: DW] = r_det;
        o_job[NE*AW+DW]    = (r_det == '0);
    end

endmodule

// ----- src/mi3_div.sv -----
module mi3_div #(
    parameter int EW = mi3_pkg::ELEMENT_WIDTH,
    parameter int FB = mi3_pkg::FRACTION_BITS
) (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_valid,
    output logic                                        o_ready,
    input  logic [mi3_pkg::NUM_ELEMS*(2*EW+1)+3*EW+3:0] i_job,
    output logic                                        o_tvalid,
    input  logic                                        i_tready,
    output logic [((mi3_pkg::NUM_ELEMS*EW+7)/8)*8-1:0]  o_tdata,
    output logic [1:0]                                  o_tuser
);

    localparam int NE = mi3_pkg::NUM_ELEMS;
    localparam int AW = 2 * EW + 1;
    localparam int DW = 3 * EW + 3;
    localparam int NW = AW + 2 * FB;
    localparam int CW = (NW > DW + EW) ? NW : DW + EW;
    localparam int QW = EW + 1;
    localparam int KW = $clog2(EW + 1);
    localparam int OW = ((NE * EW + 7) / 8) * 8;
    localparam logic [EW-1:0] HALF = EW'(1) << (EW - 1);
    localparam logic [EW-1:0] POS_MAX = HALF - 1'b1;

    logic              r_run;
    logic              r_fin;
    logic              r_ovld;
    logic [KW-1:0]     r_k;
    logic [CW-1:0]     r_rem [NE];
    logic [QW-1:0]     r_q [NE];
    logic              r_neg [NE];
    logic [CW-1:0]     r_dsh;
    logic              r_sing;
    logic [OW-1:0]     r_data;
    logic [1:0]        r_user;
    logic              w_take;
    logic              w_emit;
    logic [OW-1:0]     w_data;
    logic              w_clip;
    logic signed [AW-1:0] w_adj [NE];
    logic signed [DW-1:0] w_det;
    logic [DW-1:0]     w_dmag;

    assign o_ready  = !r_run && !r_fin;
    assign w_take   = i_valid && o_ready;
    assign w_emit   = r_fin && (!r_ovld || i_tready);
    assign o_tvalid = r_ovld;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;

    always_comb begin
        for (int i = 0; i < NE; i++) begin
            w_adj[i] = i_job[i*AW +: AW];
        end
        w_det  = i_job[NE*AW +: DW];
        w_dmag = w_det[DW-1] ? DW'(-w_det) : DW'(w_det);
    end

    // Saturating sign restore of the nine quotients, all zero for a singular matrix.
    always_comb begin
        logic [EW-1:0] mag;
        logic          sat;
        w_data = '0;
        w_clip = 1'b0;
        for (int i = 0; i < NE; i++) begin
            mag = r_q[i][EW-1:0];
            if (!r_neg[i]) begin
                sat = r_q[i][EW] || mag[EW-1];
                w_data[i*EW +: EW] = sat ? POS_MAX : mag;
            end else begin
                sat = r_q[i][EW] || (mag > HALF);
                w_data[i*EW +: EW] = sat ? HALF : EW'(-mag);
            end
            w_clip = w_clip || sat;
        end
        if (r_sing) begin
            w_data = '0;
            w_clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int i = 0; i < NE; i++) begin
                r_rem[i] <= (w_adj[i][AW-1] ? CW'(AW'(-w_adj[i])) : CW'(AW'(w_adj[i])))
                            << (2 * FB);
                r_neg[i] <= w_adj[i][AW-1] ^ w_det[DW-1];
                r_q[i]   <= '0;
            end
            r_dsh  <= CW'(w_dmag) << EW;
            r_sing <= i_job[NE*AW+DW];
            r_k    <= KW'(EW);
        end else if (r_run) begin
            for (int i = 0; i < NE; i++) begin
                if (r_rem[i] >= r_dsh) begin
                    r_rem[i] <= r_rem[i] - r_dsh;
                end
                r_q[i] <= {r_q[i][QW-2:0], (r_rem[i] >= r_dsh)};
            end
            r_dsh <= r_dsh >> 1;
            r_k   <= r_k - 1'b1;
        end
        if (w_emit) begin
            r_data <= w_data;
            r_user <= {w_clip, r_sing};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_fin  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (w_take) begin
                r_run <= 1'b1;
            end else if (r_run && r_k == '0) begin
                r_run <= 1'b0;
                r_fin <= 1'b1;
            end else if (w_emit) begin
                r_fin <= 1'b0;
            end
            if (w_emit) begin
                r_ovld <= 1'b1;
            end else if (i_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

endmodule

// ----- src/matrix3x3_inverse_adjugate_top.sv -----
// 3x3 matrix inverse by the adjugate. Each transfer on the slave side carries
// one matrix of nine signed fixed-point elements (Q16.16 by default); each
// transfer on the master side carries its inverse in the same format, with a
// singular flag (the exact determinant is zero, and then every element and the
// clipped flag are zero) and a clipped flag (some element saturated). Every
// element is the exact adjugate entry divided by the exact determinant,
// truncated toward zero. A front engine forms the adjugate and the determinant
// with one shared multiplier; a two-entry queue then feeds nine parallel
// radix-2 dividers, which take a new matrix only once the last result has left
// them for the output register. An input transfer is taken whenever the front
// holding register is free, independent of the output side, and a finished
// result waits in the output register while the next one is being divided.
module matrix3x3_inverse_adjugate_top #(
    parameter int ELEMENT_WIDTH = mi3_pkg::ELEMENT_WIDTH,
    parameter int FRACTION_BITS = mi3_pkg::FRACTION_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // Fields from the lowest bit: m00 m01 m02 m10 m11 m12 m20 m21 m22.
    input  logic [((mi3_pkg::NUM_ELEMS*ELEMENT_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // Fields from the lowest bit: inv00 inv01 inv02 inv10 inv11 inv12 inv20
    // inv21 inv22.
    output logic [((mi3_pkg::NUM_ELEMS*ELEMENT_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    // Fields from the lowest bit: singular, clipped.
    output logic [1:0] m_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready
);

    localparam int NE = mi3_pkg::NUM_ELEMS;
    localparam int JW = NE * (2 * ELEMENT_WIDTH + 1) + 3 * ELEMENT_WIDTH + 4;

    logic          w_f_valid;
    logic          w_f_ready;
    logic [JW-1:0] w_f_job;
    logic          w_q_valid;
    logic          w_q_ready;
    logic [JW-1:0] w_q_job;

    // Front: input holding register, adjugate and determinant, singular test.
    mi3_front #(
        .EW(ELEMENT_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata[NE*ELEMENT_WIDTH-1:0]),
        .o_valid (w_f_valid),
        .i_ready (w_f_ready),
        .o_job   (w_f_job)
    );

    // Short queue so that the multiplier engine and the dividers stall apart.
    mi3_fifo #(
        .WIDTH(JW),
        .DEPTH(mi3_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_f_valid),
        .o_ready (w_f_ready),
        .i_data  (w_f_job),
        .o_valid (w_q_valid),
        .i_ready (w_q_ready),
        .o_data  (w_q_job)
    );

    // Back: nine dividers, saturation and the output register.
    mi3_div #(
        .EW(ELEMENT_WIDTH),
        .FB(FRACTION_BITS)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .o_ready  (w_q_ready),
        .i_job    (w_q_job),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tuser  (m_axis_tuser)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int EW = mi3_pkg::ELEMENT_WIDTH;
    localparam int FB = mi3_pkg::FRACTION_BITS;
    localparam int NE = mi3_pkg::NUM_ELEMS;
    localparam int DW = ((NE * EW + 7) / 8) * 8;
    localparam int N_RANDOM = 1950;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [255:0] acc_t;

    typedef struct {
        elem_t inv [NE];
        logic  singular;
        logic  clipped;
    } inverse_t;

    logic i_clk;
    logic i_rst_n;
    logic [DW-1:0] s_axis_tdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [DW-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;

    logic [DW-1:0] matrices_pending [$];
    inverse_t inverses_due [$];
    int n_fail = 0;
    int n_sent = 0;
    int n_got = 0;
    int n_singular = 0;
    int n_clipped = 0;
    bit feed_done = 0;
    int hold_cycles = 0;
    bit in_taken = 0;

    matrix3x3_inverse_adjugate_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Exact adjugate over the determinant, truncated and saturated.
    function automatic inverse_t invert_matrix(logic [DW-1:0] word);
        acc_t a [NE];
        acc_t adj [NE];
        acc_t det, num, den, q;
        acc_t hi_lim, lo_lim;
        inverse_t r;
        bit neg;
        for (int i = 0; i < NE; i++) a[i] = acc_t'($signed(word[i*EW +: EW]));
        det = a[0]*a[4]*a[8] + a[3]*a[7]*a[2] + a[6]*a[1]*a[5]
            - a[2]*a[4]*a[6] - a[5]*a[7]*a[0] - a[8]*a[1]*a[3];
        r.clipped = 1'b0;
        r.singular = (det == 0);
        if (r.singular) begin
            for (int i = 0; i < NE; i++) r.inv[i] = '0;
            return r;
        end
        adj[0] = a[4]*a[8] - a[5]*a[7];
        adj[1] = a[2]*a[7] - a[1]*a[8];
        adj[2] = a[1]*a[5] - a[2]*a[4];
        adj[3] = a[5]*a[6] - a[3]*a[8];
        adj[4] = a[0]*a[8] - a[2]*a[6];
        adj[5] = a[2]*a[3] - a[0]*a[5];
        adj[6] = a[3]*a[7] - a[4]*a[6];
        adj[7] = a[1]*a[6] - a[0]*a[7];
        adj[8] = a[0]*a[4] - a[1]*a[3];
        hi_lim = (acc_t'(1) <<< (EW - 1)) - 1;
        lo_lim = -(acc_t'(1) <<< (EW - 1));
        for (int i = 0; i < NE; i++) begin
            num = adj[i] <<< (2 * FB);
            neg = (num < 0) != (det < 0);
            if (num < 0) num = -num;
            den = (det < 0) ? -det : det;
            q = num / den;
            if (neg) q = -q;
            if (q > hi_lim) begin
                q = hi_lim; r.clipped = 1'b1;
            end else if (q < lo_lim) begin
                q = lo_lim; r.clipped = 1'b1;
            end
            r.inv[i] = q[EW-1:0];
        end
        return r;
    endfunction

    function automatic elem_t pick_element(int mode);
        case (mode)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(0, 8 << FB)) - (4 << FB));
            2: return elem_t'($signed($urandom_range(0, 64)) - 32);
            default: begin
                case ($urandom_range(0, 5))
                    0: return {1'b1, {(EW-1){1'b0}}};
                    1: return {1'b0, {(EW-1){1'b1}}};
                    2: return '0;
                    3: return elem_t'(1 << FB);
                    4: return elem_t'(-1);
                    default: return elem_t'(1);
                endcase
            end
        endcase
    endfunction

    function automatic logic [DW-1:0] pack_matrix(elem_t e [NE]);
        logic [DW-1:0] w;
        w = '0;
        for (int i = 0; i < NE; i++) w[i*EW +: EW] = e[i];
        return w;
    endfunction

    // Directed matrices, then random ones.
    initial begin
        elem_t e [NE];
        elem_t one, mx, mn;
        int mode;
        one = elem_t'(1 << FB);
        mx = {1'b0, {(EW-1){1'b1}}};
        mn = {1'b1, {(EW-1){1'b0}}};
        // Identity, a diagonal matrix, tiny determinants, singular cases, extreme elements and a permutation.
        e = '{one, 0, 0, 0, one, 0, 0, 0, one};
        matrices_pending.push_back(pack_matrix(e));
        e = '{2*one, 0, 0, 0, -one/2, 0, 0, 0, 4*one};
        matrices_pending.push_back(pack_matrix(e));
        e = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        matrices_pending.push_back(pack_matrix(e));
        e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        matrices_pending.push_back(pack_matrix(e));
        e = '{one, 2*one, 3*one, 4*one, 5*one, 6*one, 7*one, 8*one, 9*one};
        matrices_pending.push_back(pack_matrix(e));
        e = '{mx, mx, mx, mx, mx, mx, mx, mx, mx};
        matrices_pending.push_back(pack_matrix(e));
        e = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};
        matrices_pending.push_back(pack_matrix(e));
        e = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};
        matrices_pending.push_back(pack_matrix(e));
        e = '{mn, mx, 0, 1, mn, mx, mx, 1, mn};
        matrices_pending.push_back(pack_matrix(e));
        e = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
        matrices_pending.push_back(pack_matrix(e));
        e = '{0, one, 0, 0, 0, one, one, 0, 0};
        matrices_pending.push_back(pack_matrix(e));
        e = '{mn, mn, mn, mx, mx, mx, 1, 2, 3};
        matrices_pending.push_back(pack_matrix(e));
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 3);
            for (int i = 0; i < NE; i++) e[i] = pick_element(mode);
            // Some matrices are made singular by repeating a row.
            if ($urandom_range(0, 9) == 0) begin
                e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
            end
            matrices_pending.push_back(pack_matrix(e));
        end
    end

    function automatic int gap_length();
        if ($urandom_range(0, 3) != 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(20, 120);
        return $urandom_range(1, 4);
    endfunction

    // The input handshake is seen at the rising edge, before the block reacts to it.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
    end

    // Driver: offers the head of the queue and pauses at random between transfers.
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (in_taken) begin
                inverses_due.push_back(invert_matrix(s_axis_tdata));
                n_sent++;
                void'(matrices_pending.pop_front());
                tx_gap = gap_length();
            end
            if (s_axis_tvalid && !in_taken) begin
                // Keep offering the same matrix.
            end else if (tx_gap > 0 || matrices_pending.size() == 0) begin
                if (tx_gap > 0) tx_gap--;
                s_axis_tvalid <= 1'b0;
                if (matrices_pending.size() == 0) feed_done = 1;
            end else begin
                s_axis_tdata <= matrices_pending[0];
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // Receiver back-pressure, with one long hold-off early on so that the block fills.
    int rx_gap = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (n_sent >= 20 && n_sent < 40 && hold_cycles < 600) begin
            hold_cycles++;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if ($urandom_range(0, 99) < 30) rx_gap = gap_length();
        end
    end

    // Monitor: compare every transfer with the oldest prediction.
    always @(posedge i_clk) begin
        inverse_t want;
        elem_t got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            n_got++;
            if (inverses_due.size() == 0) begin
                $error("result with no matrix outstanding");
                n_fail++;
            end else begin
                want = inverses_due.pop_front();
                for (int i = 0; i < NE; i++) begin
                    got = m_axis_tdata[i*EW +: EW];
                    if (got !== want.inv[i]) begin
                        $error("inv%0d%0d: expected %0d, got %0d", i / 3, i % 3,
                               want.inv[i], got);
                        n_fail++;
                    end
                end
                if (m_axis_tuser[0] !== want.singular) begin
                    $error("singular: expected %0b, got %0b", want.singular,
                           m_axis_tuser[0]);
                    n_fail++;
                end
                if (m_axis_tuser[1] !== want.clipped) begin
                    $error("clipped: expected %0b, got %0b", want.clipped,
                           m_axis_tuser[1]);
                    n_fail++;
                end
                if (want.singular) n_singular++;
                if (want.clipped) n_clipped++;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        wait (feed_done && inverses_due.size() == 0 && !s_axis_tvalid);
        repeat (100) @(posedge i_clk);
        if (inverses_due.size() != 0) n_fail++;
        $display("Checked %0d inverses from %0d matrices: %0d singular, %0d clipped.",
                 n_got, n_sent, n_singular, n_clipped);
        $display("Random gaps on both sides, with one long output hold-off.");
        if (n_fail == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("tb_top failed");
        $finish;
    end

endmodule

// ----- files.f -----
src/mi3_pkg.sv
src/mi3_fifo.sv
src/mi3_front.sv
src/mi3_div.sv
src/matrix3x3_inverse_adjugate_top.sv
sim/tb_top.sv
